[rtl/layer_energy_centroid_accumulator_macros.svh]
// Assertion macros for the layer energy centroid accumulator.
// Each macro expects clk_i and rst_ni in scope of the module that uses it.
`ifndef LAYER_ENERGY_CENTROID_ACCUMULATOR_MACROS_SVH
`define LAYER_ENERGY_CENTROID_ACCUMULATOR_MACROS_SVH

// Plain property checked on every clock edge outside reset.
`define LEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication checked on every clock edge outside reset.
`define LEC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define LEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/lec_pkg.sv]
// Shared types, constants and arithmetic helpers of the centroid accumulator.
// No dependencies; every other file but the assertion macro header imports this package.
package lec_pkg;

  localparam int NUM_LAYERS_DEF = 32;
  localparam int LAYER_W        = 5;
  localparam int E_W            = 24;
  localparam int POS_W          = 20;
  localparam int T_W            = 24;
  localparam int ESUM_W         = 32;
  localparam int WSUM_W         = 64;
  localparam int MID_W          = POS_W + 1;
  localparam int MIDT_W         = T_W + 1;
  localparam int PRODP_W        = MID_W + E_W;
  localparam int PRODT_W        = MIDT_W + E_W;
  localparam int QUO_W          = 25;
  localparam int DIVR_W         = ESUM_W + 1;
  localparam int QUEUE_DEPTH    = 4;
  localparam int N_LANES        = 4;
  localparam int LANE_X         = 0;
  localparam int LANE_Y         = 1;
  localparam int LANE_Z         = 2;
  localparam int LANE_T         = 3;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic                     is_end;
    logic [LAYER_W-1:0]       layer;
    logic [E_W-1:0]           energy;
    logic signed [MID_W-1:0]  mx;
    logic signed [MID_W-1:0]  my;
    logic signed [MID_W-1:0]  mz;
    logic [MIDT_W-1:0]        mt;
  } item_t;

  // Accumulator set of one layer.
  typedef struct packed {
    logic [ESUM_W-1:0] esum;
    logic [WSUM_W-1:0] wx;
    logic [WSUM_W-1:0] wy;
    logic [WSUM_W-1:0] wz;
    logic [WSUM_W-1:0] wt;
  } acc_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
  } div_stat_t;

  // Signed add that sticks at the 64-bit limits.
  function automatic logic [WSUM_W-1:0] sat_add_s(input logic [WSUM_W-1:0] a,
                                                  input logic [WSUM_W-1:0] b);
    logic [WSUM_W-1:0] s;
    s = a + b;
    if ((a[WSUM_W-1] == b[WSUM_W-1]) && (s[WSUM_W-1] != a[WSUM_W-1])) begin
      s = a[WSUM_W-1] ? {1'b1, {(WSUM_W-1){1'b0}}} : {1'b0, {(WSUM_W-1){1'b1}}};
    end
    return s;
  endfunction

  // Signs a saturated quotient magnitude and clamps it to the position range.
  function automatic logic [POS_W-1:0] clamp_pos(input logic neg,
                                                 input logic [QUO_W-1:0] q);
    logic [POS_W-1:0] r;
    if (neg) begin
      r = (q > QUO_W'(524288)) ? {1'b1, {(POS_W-1){1'b0}}} : POS_W'(~q + QUO_W'(1));
    end else begin
      r = (q > QUO_W'(524287)) ? {1'b0, {(POS_W-1){1'b1}}} : q[POS_W-1:0];
    end
    return r;
  endfunction

  // Clamps a saturated quotient to the time range.
  function automatic logic [T_W-1:0] clamp_time(input logic [QUO_W-1:0] q);
    return q[QUO_W-1] ? {T_W{1'b1}} : q[T_W-1:0];
  endfunction

endpackage

[rtl/lec_in_if.sv]
// Input channel of the centroid accumulator: valid, ready and the item fields.
// Depends on lec_pkg for field widths.
interface lec_in_if;
  import lec_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [LAYER_W-1:0]       layer;
  logic [E_W-1:0]           energy;
  logic signed [POS_W-1:0]  pre_x;
  logic signed [POS_W-1:0]  pre_y;
  logic signed [POS_W-1:0]  pre_z;
  logic [T_W-1:0]           pre_time;
  logic signed [POS_W-1:0]  post_x;
  logic signed [POS_W-1:0]  post_y;
  logic signed [POS_W-1:0]  post_z;
  logic [T_W-1:0]           post_time;

  modport source (output valid, kind, layer, energy, pre_x, pre_y, pre_z, pre_time,
                  post_x, post_y, post_z, post_time, input ready);
  modport sink   (input valid, kind, layer, energy, pre_x, pre_y, pre_z, pre_time,
                  post_x, post_y, post_z, post_time, output ready);
endinterface

[rtl/lec_out_if.sv]
// Output channel of the centroid accumulator: valid, ready and the summary fields.
// Depends on lec_pkg for field widths.
interface lec_out_if;
  import lec_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [LAYER_W-1:0]       out_layer;
  logic [ESUM_W-1:0]        energy_total;
  logic signed [POS_W-1:0]  centroid_x;
  logic signed [POS_W-1:0]  centroid_y;
  logic signed [POS_W-1:0]  centroid_z;
  logic [T_W-1:0]           centroid_time;
  logic                     last_layer;

  modport source (output valid, out_layer, energy_total, centroid_x, centroid_y,
                  centroid_z, centroid_time, last_layer, input ready);
  modport sink   (input valid, out_layer, energy_total, centroid_x, centroid_y,
                  centroid_z, centroid_time, last_layer, output ready);
endinterface

[rtl/lec_front.sv]
// Front end: accepts input beats, drops empty or out-of-range deposits and
// forms the unhalved step midpoints. Depends on lec_pkg and lec_in_if.
module lec_front #(
  parameter int NUM_LAYERS = lec_pkg::NUM_LAYERS_DEF
) (
  lec_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output lec_pkg::item_t  item_o
);
  import lec_pkg::*;

  logic keep;

  // A beat is taken whenever the queue has room.
  assign in_i.ready = !full_i;

  // End-of-event beats always pass; deposits only with energy in a real layer.
  assign keep = in_i.kind ||
                ((in_i.energy != '0) && ((LAYER_W + 2)'(in_i.layer) < (LAYER_W + 2)'(NUM_LAYERS)));
  assign push_o = in_i.valid && !full_i && keep;

  // Midpoints are carried doubled, as pre + post.
  always_comb begin
    item_o.is_end = in_i.kind;
    item_o.layer  = in_i.layer;
    item_o.energy = in_i.energy;
    item_o.mx     = MID_W'(in_i.pre_x) + MID_W'(in_i.post_x);
    item_o.my     = MID_W'(in_i.pre_y) + MID_W'(in_i.post_y);
    item_o.mz     = MID_W'(in_i.pre_z) + MID_W'(in_i.post_z);
    item_o.mt     = MIDT_W'(in_i.pre_time) + MIDT_W'(in_i.post_time);
  end
endmodule

[rtl/lec_fifo.sv]
// Short queue of classified items between the front and the back.
// Depends on lec_pkg.
module lec_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lec_pkg::item_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output lec_pkg::item_t  data_o
);
  import lec_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t         slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign full_o  = (cnt_q == (PW + 1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_q];

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PW'(1);
      end
      cnt_q <= cnt_q + (PW + 1)'(push_i) - (PW + 1)'(pop_i);
    end
  end
endmodule

[rtl/lec_div.sv]
// Four-lane radix-2 divider sharing one divisor, with quotients saturated
// to 25 bits. Depends on lec_pkg.
module lec_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lec_pkg::div_ctrl_t               ctrl_i,
  input  logic [lec_pkg::N_LANES-1:0][lec_pkg::WSUM_W-1:0] dividend_i,
  input  logic [lec_pkg::DIVR_W-1:0]       divisor_i,
  output lec_pkg::div_stat_t               stat_o,
  output logic [lec_pkg::N_LANES-1:0][lec_pkg::QUO_W-1:0]  quot_o
);
  import lec_pkg::*;

  localparam int CNT_W = $clog2(WSUM_W);

  logic                                busy_q;
  logic [CNT_W-1:0]                    cnt_q;
  logic [DIVR_W-1:0]                   div_q;
  logic [N_LANES-1:0][WSUM_W-1:0]      dvd_q;
  logic [N_LANES-1:0][DIVR_W-1:0]      rem_q, rem_d;
  logic [N_LANES-1:0][QUO_W-1:0]       q_q;
  logic [N_LANES-1:0]                  ovf_q, ge;
  logic [N_LANES-1:0][DIVR_W:0]        rem_sh;

  // One quotient bit per lane per cycle.
  always_comb begin
    for (int l = 0; l < N_LANES; l++) begin
      rem_sh[l] = {rem_q[l], dvd_q[l][WSUM_W-1]};
      ge[l]     = (rem_sh[l] >= {1'b0, div_q});
      rem_d[l]  = ge[l] ? DIVR_W'(rem_sh[l] - {1'b0, div_q}) : rem_sh[l][DIVR_W-1:0];
      quot_o[l] = ovf_q[l] ? {QUO_W{1'b1}} : q_q[l];
    end
  end

  assign stat_o.busy = busy_q;

  // Sequencing of the 64 steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(WSUM_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Lane datapath.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      div_q <= divisor_i;
      for (int l = 0; l < N_LANES; l++) begin
        dvd_q[l] <= dividend_i[l];
        rem_q[l] <= '0;
        q_q[l]   <= '0;
        ovf_q[l] <= 1'b0;
      end
    end else if (busy_q) begin
      for (int l = 0; l < N_LANES; l++) begin
        dvd_q[l] <= {dvd_q[l][WSUM_W-2:0], 1'b0};
        rem_q[l] <= rem_d[l];
        q_q[l]   <= {q_q[l][QUO_W-2:0], ge[l]};
        ovf_q[l] <= ovf_q[l] | q_q[l][QUO_W-1];
      end
    end
  end
endmodule

[rtl/lec_back.sv]
// Back end: per-layer accumulator memory, deposit read-modify-write and the
// end-of-event scan with centroid division. Depends on lec_pkg, lec_div, lec_out_if.
module lec_back #(
  parameter int NUM_LAYERS = lec_pkg::NUM_LAYERS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  lec_pkg::item_t  item_i,
  output logic            pop_o,
  lec_out_if.source       out_o
);
  import lec_pkg::*;
  `include "layer_energy_centroid_accumulator_macros.svh"

  localparam int LW = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
  localparam int CW = $clog2(NUM_LAYERS + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_ADD  = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_DIVS = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e                      state_q, state_d;
  acc_t                        mem_q [NUM_LAYERS];
  logic [NUM_LAYERS-1:0]       valid_q;
  item_t                       item_q;
  logic [LW-1:0]               addr_q, rd_addr;
  acc_t                        rd_q, acc, acc_new;
  logic                        rvld_q, rd_en, hit, last_c, last_q, scan_end, load_out;
  logic [CW-1:0]               idx_q;
  logic signed [PRODP_W-1:0]   px_q, py_q, pz_q;
  logic [PRODT_W-1:0]          pt_q;
  logic [ESUM_W:0]             esum_wide;
  logic [WSUM_W:0]             wt_wide;
  div_ctrl_t                   div_ctrl;
  div_stat_t                   div_stat;
  logic [N_LANES-1:0][WSUM_W-1:0] dvd;
  logic [N_LANES-1:0][QUO_W-1:0]  quot;

  // Scan position and lookahead for the final summary of the event.
  assign scan_end = (idx_q == CW'(NUM_LAYERS));
  assign hit      = (state_q == S_SCAN) && !scan_end && valid_q[idx_q[LW-1:0]];
  always_comb begin
    last_c = 1'b1;
    for (int j = 0; j < NUM_LAYERS; j++) begin
      if ((CW + 1)'(j) > (CW + 1)'(idx_q) && valid_q[j]) begin
        last_c = 1'b0;
      end
    end
  end

  // Single read port shared by deposits and the scan.
  assign pop_o   = (state_q == S_IDLE) && valid_i;
  assign rd_en   = pop_o || hit;
  assign rd_addr = (state_q == S_SCAN) ? idx_q[LW-1:0] : LW'(item_i.layer);
  assign acc     = rvld_q ? rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q   <= mem_q[rd_addr];
      rvld_q <= valid_q[rd_addr];
    end
    if (state_q == S_ADD) begin
      mem_q[addr_q] <= acc_new;
    end
  end

  // Saturating accumulation of one deposit.
  always_comb begin
    esum_wide      = {1'b0, acc.esum} + (ESUM_W + 1)'(item_q.energy);
    wt_wide        = {1'b0, acc.wt} + (WSUM_W + 1)'(pt_q);
    acc_new.esum   = esum_wide[ESUM_W] ? {ESUM_W{1'b1}} : esum_wide[ESUM_W-1:0];
    acc_new.wx     = sat_add_s(acc.wx, WSUM_W'(px_q));
    acc_new.wy     = sat_add_s(acc.wy, WSUM_W'(py_q));
    acc_new.wz     = sat_add_s(acc.wz, WSUM_W'(pz_q));
    acc_new.wt     = wt_wide[WSUM_W] ? {WSUM_W{1'b1}} : wt_wide[WSUM_W-1:0];
  end

  // Divider operands: magnitudes of the weighted sums over twice the energy.
  always_comb begin
    dvd[LANE_X] = acc.wx[WSUM_W-1] ? (~acc.wx + WSUM_W'(1)) : acc.wx;
    dvd[LANE_Y] = acc.wy[WSUM_W-1] ? (~acc.wy + WSUM_W'(1)) : acc.wy;
    dvd[LANE_Z] = acc.wz[WSUM_W-1] ? (~acc.wz + WSUM_W'(1)) : acc.wz;
    dvd[LANE_T] = acc.wt;
  end
  assign div_ctrl.start = (state_q == S_DIVS);

  lec_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (dvd),
    .divisor_i  ({acc.esum, 1'b0}),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  // Sequencer next state.
  assign load_out = (state_q == S_OUT) && (!out_o.valid || out_o.ready);
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (valid_i) state_d = item_i.is_end ? S_SCAN : S_MUL;
      S_MUL:  state_d = S_ADD;
      S_ADD:  state_d = S_IDLE;
      S_SCAN: begin
        if (scan_end) begin
          state_d = S_IDLE;
        end else if (hit) begin
          state_d = S_DIVS;
        end
      end
      S_DIVS: state_d = S_DIV;
      S_DIV:  if (!div_stat.busy) state_d = S_OUT;
      S_OUT:  if (load_out) state_d = S_SCAN;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (pop_o && item_i.is_end) begin
        idx_q <= '0;
      end else if ((state_q == S_SCAN && !scan_end && !hit) || load_out) begin
        idx_q <= idx_q + CW'(1);
      end
      if (state_q == S_ADD) begin
        valid_q[addr_q] <= 1'b1;
      end
      if (hit) begin
        valid_q[idx_q[LW-1:0]] <= 1'b0;
      end
    end
  end

  // Item latch and product stage.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
      addr_q <= LW'(item_i.layer);
    end
    if (hit) begin
      last_q <= last_c;
    end
    if (state_q == S_MUL) begin
      px_q <= PRODP_W'(item_q.mx * $signed({1'b0, item_q.energy}));
      py_q <= PRODP_W'(item_q.my * $signed({1'b0, item_q.energy}));
      pz_q <= PRODP_W'(item_q.mz * $signed({1'b0, item_q.energy}));
      pt_q <= PRODT_W'(item_q.mt * item_q.energy);
    end
  end

  // Output register: holds a summary until the receiver takes the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.valid <= 1'b0;
    end else if (load_out) begin
      out_o.valid <= 1'b1;
    end else if (out_o.ready) begin
      out_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_o.out_layer     <= LAYER_W'(idx_q);
      out_o.energy_total  <= acc.esum;
      out_o.centroid_x    <= clamp_pos(acc.wx[WSUM_W-1], quot[LANE_X]);
      out_o.centroid_y    <= clamp_pos(acc.wy[WSUM_W-1], quot[LANE_Y]);
      out_o.centroid_z    <= clamp_pos(acc.wz[WSUM_W-1], quot[LANE_Z]);
      out_o.centroid_time <= clamp_time(quot[LANE_T]);
      out_o.last_layer    <= last_q;
    end
  end

  // A summary only appears after a completed division.
  `LEC_ASSERT_IMPL(a_out_from_seq, $rose(out_o.valid), $past(state_q == S_OUT),
                   "summary raised outside the output state")
  // The final summary of an event leaves no layer marked nonempty.
  `LEC_ASSERT_NEXT(a_last_clears, load_out && last_q, valid_q == '0,
                   "layers still nonempty after the final summary")
  // A deposit write marks its layer nonempty.
  `LEC_ASSERT_NEXT(a_add_marks, state_q == S_ADD, valid_q[$past(addr_q)],
                   "deposit did not mark its layer")
  // The divider is never restarted while it runs.
  `LEC_ASSERT_IMPL(a_div_idle_start, div_ctrl.start, !div_stat.busy,
                   "divider started while busy")
endmodule

[rtl/layer_energy_centroid_accumulator.sv]
// Top level of the layer energy centroid accumulator.
// Depends on lec_pkg, lec_in_if, lec_out_if, lec_front, lec_fifo and lec_back.
//
// Usage: in_i carries deposit beats (kind 0) and end-of-event beats (kind 1).
// A deposit adds its energy and the energy-weighted step midpoint to its layer;
// zero-energy deposits and layers at or beyond NUM_LAYERS are dropped at the front.
// An end-of-event beat makes the block walk the layers in ascending order and
// send one summary beat on out_o per nonempty layer, the last one flagged by
// last_layer, clearing each layer as it goes.
// Throughput: in_i takes a beat every cycle while the four-entry queue has room.
// The back end handles each deposit in three steps (read, multiply, saturating
// write through one memory port) before it takes the next item. An end of
// event steps past each empty layer and, for each nonempty one, runs the
// 64-step radix-2 divider that forms the four centroids in parallel, then
// loads the summary into the output register.
// Reset clears all layer accumulators at once through per-layer valid bits.
// When the receiver stalls, the summary waits in the output register and the
// scan pauses; deposits then collect in the queue and in_i drops ready when full.
module layer_energy_centroid_accumulator #(
  parameter int NUM_LAYERS = lec_pkg::NUM_LAYERS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lec_in_if.sink     in_i,
  lec_out_if.source  out_o
);
  import lec_pkg::*;

  logic  push, full, q_valid, pop;
  item_t push_item, head_item;

  lec_front #(.NUM_LAYERS(NUM_LAYERS)) u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  lec_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_item)
  );

  lec_back #(.NUM_LAYERS(NUM_LAYERS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .item_i  (head_item),
    .pop_o   (pop),
    .out_o   (out_o)
  );
endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the layer energy centroid accumulator.
// Depends on lec_pkg, lec_in_if, lec_out_if and the top level of the block.
`timescale 1ns / 1ps

module tb_top;
  import lec_pkg::*;

  // Input beat as the sender sees it.
  typedef struct packed {
    logic                    kind;
    logic [LAYER_W-1:0]      layer;
    logic [E_W-1:0]          energy;
    logic signed [POS_W-1:0] pre_x;
    logic signed [POS_W-1:0] pre_y;
    logic signed [POS_W-1:0] pre_z;
    logic [T_W-1:0]          pre_time;
    logic signed [POS_W-1:0] post_x;
    logic signed [POS_W-1:0] post_y;
    logic signed [POS_W-1:0] post_z;
    logic [T_W-1:0]          post_time;
  } step_t;

  // One layer summary beat.
  typedef struct packed {
    logic [LAYER_W-1:0]      out_layer;
    logic [ESUM_W-1:0]       energy_total;
    logic signed [POS_W-1:0] centroid_x;
    logic signed [POS_W-1:0] centroid_y;
    logic signed [POS_W-1:0] centroid_z;
    logic [T_W-1:0]          centroid_time;
    logic                    last_layer;
  } summary_t;

  // Directed row: a beat and, where it is obvious, the summary it must cause.
  typedef struct packed {
    step_t    beat;
    logic     typed;
    summary_t summary;
  } row_t;

  localparam int       NLAYERS   = 32;
  localparam logic     KIND_DEP  = 1'b0;
  localparam logic     KIND_END  = 1'b1;
  localparam int       DRAIN     = 300;
  localparam int       STEP_W    = $bits(step_t);
  localparam int       EXP_DEPTH = 1024;
  localparam int       MAX_ROWS  = 64;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lec_in_if  in_bus ();
  lec_out_if out_bus ();

  layer_energy_centroid_accumulator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #4 clk_i = ~clk_i;

  // Shadow accumulators of every layer.
  logic [ESUM_W-1:0] shadow_energy [NLAYERS];
  longint            shadow_wx     [NLAYERS];
  longint            shadow_wy     [NLAYERS];
  longint            shadow_wz     [NLAYERS];
  longint unsigned   shadow_wt     [NLAYERS];

  // Expected summaries in arrival order, kept as a ring with running counts.
  summary_t exp_fifo [EXP_DEPTH];
  int       exp_wr = 0;
  int       exp_rd = 0;
  row_t     directed_rows [MAX_ROWS];
  int       n_rows       = 0;
  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;
  int       mismatches   = 0;
  int       summaries_seen = 0;
  int       beats_sent   = 0;
  int       events_sent  = 0;

  function automatic void append_summary(input summary_t sm);
    exp_fifo[exp_wr % EXP_DEPTH] = sm;
    exp_wr++;
  endfunction

  function automatic void add_row(input row_t r);
    directed_rows[n_rows] = r;
    n_rows++;
  endfunction

  // Signed add that sticks at the 64-bit limits.
  function automatic longint sat_add(input longint a, input longint b);
    logic signed [64:0] r;
    r = $signed({a[63], a}) + $signed({b[63], b});
    if (r[64] != r[63]) return r[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return r[63:0];
  endfunction

  // Weighted position sum over twice the energy, truncated and clamped.
  function automatic logic [POS_W-1:0] mean_pos(input longint s, input logic [ESUM_W-1:0] e);
    logic [63:0] mag, q, div;
    div = {31'd0, e, 1'b0};
    mag = s[63] ? (~s + 64'd1) : s;
    q   = mag / div;
    if (s[63]) return (q > 64'd524288) ? 20'h80000 : POS_W'(~q + 64'd1);
    return (q > 64'd524287) ? 20'h7FFFF : q[POS_W-1:0];
  endfunction

  // Applies one accepted beat to the shadow state; an end of event queues summaries when queue_it is set.
  function automatic void accumulate_step(input step_t b, input bit queue_it);
    longint          e, mx, my, mz;
    longint unsigned mt, prod, ts;
    logic [ESUM_W:0] es;
    logic [63:0]     qt;
    summary_t        sm;
    int              last_idx;
    if (b.kind == KIND_DEP) begin
      if (b.energy == 0) return;
      e  = longint'(b.energy);
      mx = longint'(b.pre_x) + longint'(b.post_x);
      my = longint'(b.pre_y) + longint'(b.post_y);
      mz = longint'(b.pre_z) + longint'(b.post_z);
      mt = longint'(b.pre_time) + longint'(b.post_time);
      es = {1'b0, shadow_energy[b.layer]} + b.energy;
      shadow_energy[b.layer] = es[ESUM_W] ? {ESUM_W{1'b1}} : es[ESUM_W-1:0];
      shadow_wx[b.layer] = sat_add(shadow_wx[b.layer], mx * e);
      shadow_wy[b.layer] = sat_add(shadow_wy[b.layer], my * e);
      shadow_wz[b.layer] = sat_add(shadow_wz[b.layer], mz * e);
      prod = mt * longint'(b.energy);
      ts   = shadow_wt[b.layer] + prod;
      shadow_wt[b.layer] = (ts < prod) ? {64{1'b1}} : ts;
      return;
    end
    last_idx = -1;
    for (int i = 0; i < NLAYERS; i++) begin
      if (shadow_energy[i] == 0) continue;
      sm.out_layer     = LAYER_W'(i);
      sm.energy_total  = shadow_energy[i];
      sm.centroid_x    = mean_pos(shadow_wx[i], shadow_energy[i]);
      sm.centroid_y    = mean_pos(shadow_wy[i], shadow_energy[i]);
      sm.centroid_z    = mean_pos(shadow_wz[i], shadow_energy[i]);
      qt = shadow_wt[i] / {31'd0, shadow_energy[i], 1'b0};
      sm.centroid_time = (qt > 64'hFFFFFF) ? {T_W{1'b1}} : qt[T_W-1:0];
      sm.last_layer    = 1'b0;
      if (queue_it) begin
        last_idx = exp_wr;
        append_summary(sm);
      end
      shadow_energy[i] = '0;
      shadow_wx[i] = 0;
      shadow_wy[i] = 0;
      shadow_wz[i] = 0;
      shadow_wt[i] = 0;
    end
    if (last_idx >= 0) exp_fifo[last_idx % EXP_DEPTH].last_layer = 1'b1;
  endfunction

  function automatic step_t deposit(input int lyr, input int en, input int px, input int py,
                                    input int pz, input int pt, input int qx, input int qy,
                                    input int qz, input int qt);
    step_t b;
    b = '{KIND_DEP, LAYER_W'(lyr), E_W'(en), POS_W'(px), POS_W'(py), POS_W'(pz), T_W'(pt),
          POS_W'(qx), POS_W'(qy), POS_W'(qz), T_W'(qt)};
    return b;
  endfunction

  // End of event with random content in the ignored fields.
  function automatic step_t end_of_event();
    step_t b;
    b = STEP_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom()});
    b.kind = KIND_END;
    return b;
  endfunction

  function automatic step_t random_deposit(input int lyr);
    step_t b;
    int    pick;
    b = STEP_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom()});
    b.kind  = KIND_DEP;
    b.layer = LAYER_W'(lyr);
    pick = $urandom_range(0, 9);
    if (pick == 0) b.energy = '0;
    else if (pick == 1) b.energy = {E_W{1'b1}};
    else if (pick < 5) b.energy = E_W'($urandom_range(1, 255));
    if ($urandom_range(0, 7) == 0) begin
      b.pre_x = 20'h7FFFF;
      b.post_x = 20'h7FFFF;
      b.pre_y = 20'h80000;
      b.post_y = 20'h80000;
    end
    return b;
  endfunction

  // Sends one beat, idling at random, and updates the shadow state on acceptance.
  task automatic send_beat(input step_t b, input bit typed, input summary_t sm);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    {in_bus.kind, in_bus.layer, in_bus.energy, in_bus.pre_x, in_bus.pre_y, in_bus.pre_z,
     in_bus.pre_time, in_bus.post_x, in_bus.post_y, in_bus.post_z, in_bus.post_time} <= b;
    in_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!in_bus.ready);
    beats_sent++;
    if (b.kind == KIND_END) events_sent++;
    accumulate_step(b, !typed);
    if (typed) append_summary(sm);
  endtask

  // A random event: up to six beats, mostly deposits over four adjacent layers and now and then an end, then its end.
  task automatic send_event();
    int n_dep, base;
    n_dep = $urandom_range(1, 6);
    base  = $urandom_range(0, NLAYERS - 1);
    for (int k = 0; k < n_dep; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_beat(end_of_event(), 1'b0, '0);
      else
        send_beat(random_deposit((base + $urandom_range(0, 3)) % NLAYERS), 1'b0, '0);
    end
    send_beat(end_of_event(), 1'b0, '0);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    wait (exp_wr == exp_rd);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // Receiver ready, idling at random.
  always @(negedge clk_i) begin
    out_bus.ready <= rst_ni && ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Compares each summary beat with the oldest pending one.
  always @(posedge clk_i) begin
    summary_t got, want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = {out_bus.out_layer, out_bus.energy_total, out_bus.centroid_x, out_bus.centroid_y,
             out_bus.centroid_z, out_bus.centroid_time, out_bus.last_layer};
      summaries_seen++;
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected summary beat %p", got);
      end else begin
        want = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("summary mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    #(8 * 3000000);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    in_bus.valid = 1'b0;
    {in_bus.kind, in_bus.layer, in_bus.energy, in_bus.pre_x, in_bus.pre_y, in_bus.pre_z,
     in_bus.pre_time, in_bus.post_x, in_bus.post_y, in_bus.post_z, in_bus.post_time} = '0;
    for (int i = 0; i < NLAYERS; i++) begin
      shadow_energy[i] = '0;
      shadow_wx[i] = 0;
      shadow_wy[i] = 0;
      shadow_wz[i] = 0;
      shadow_wt[i] = 0;
    end

    // Directed rows: empty event after reset, extremes, a zero-energy step, rounding.
    add_row('{end_of_event(), 1'b0, '0});
    add_row('{deposit(0, 24'hFFFFFF, 524287, -524288, 524287, 24'hFFFFFF,
                      524287, -524288, -524288, 24'hFFFFFF), 1'b0, '0});
    add_row('{end_of_event(), 1'b1,
              '{5'd0, 32'hFFFFFF, 20'h7FFFF, 20'h80000, 20'h0, 24'hFFFFFF, 1'b1}});
    add_row('{deposit(31, 0, 100, 100, 100, 5, 100, 100, 100, 5), 1'b0, '0});
    add_row('{end_of_event(), 1'b0, '0});
    add_row('{deposit(31, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    add_row('{deposit(0, 1, 3, -3, 1, 1, 0, 0, 0, 2), 1'b0, '0});
    add_row('{deposit(15, 2, -3, 7, -1, 10, 0, 2, 0, 11), 1'b0, '0});
    add_row('{deposit(15, 3, 40, -40, 9, 100, 44, -41, 9, 103), 1'b0, '0});
    add_row('{end_of_event(), 1'b0, '0});
    add_row('{deposit(31, 24'hFFFFFF, -524288, -524288, -524288, 0,
                      -524288, -524288, -524288, 1), 1'b0, '0});
    add_row('{end_of_event(), 1'b1,
              '{5'd31, 32'hFFFFFF, 20'h80000, 20'h80000, 20'h80000, 24'h0, 1'b1}});
    for (int i = 0; i < NLAYERS; i++)
      add_row('{deposit(i, i + 1, i, -i, 2 * i, i, i, -i, 0, 0), 1'b0, '0});
    add_row('{end_of_event(), 1'b0, '0});

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 26;
    snk_idle_pct = 64;
    for (int r = 0; r < n_rows; r++)
      send_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].summary);

    // Random events under three idling patterns; the sender waits for a full drain
    // between patterns.
    while (beats_sent < 85) send_event();
    drain_results();
    src_idle_pct = 64;
    snk_idle_pct = 26;
    while (beats_sent < 125) send_event();
    drain_results();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    while (beats_sent < 165) send_event();
    drain_results();

    $display("Sent %0d beats in %0d events, checked %0d layer summaries.",
             beats_sent, events_sent, summaries_seen);
    $display("Covered position and time extremes, ignored steps, empty events and stalls.");
    if (mismatches == 0 && exp_wr == exp_rd) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
